### design/wildcard_byte_pattern_scan_core_defines.svh
// Assertion macros used by the checker file of the scan core.
`ifndef WILDCARD_BYTE_PATTERN_SCAN_CORE_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define WBPS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scan core check failed");

// Next-cycle implication, ignored while reset is high.
`define WBPS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scan core check failed");

// Next-cycle implication that is also checked across reset.
`define WBPS_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("scan core reset check failed");

`endif

### design/wbps_pkg.sv
package wbps_pkg;

  // Sizes of the scan window and the byte counter.
  localparam int MAX_PATTERN_BYTES = 16;
  localparam int OFFSET_BITS       = 32;

  // Field widths fixed by the interface.
  localparam int BYTE_W     = 8;
  localparam int PAT_SLOTS  = 16;
  localparam int SLOT_W     = 4;
  localparam int LEN_W      = 5;
  localparam int RESULT_W   = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int MASK_W     = 16;

  // Longest pattern that can actually be used.
  localparam int LEN_CAP = (MAX_PATTERN_BYTES < PAT_SLOTS) ? MAX_PATTERN_BYTES : PAT_SLOTS;

  // Width used to form the match offset before it is cut to the result width.
  localparam int CALC_W = (OFFSET_BITS > RESULT_W) ? OFFSET_BITS : RESULT_W;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 2'd0,
    REG_PATTERN_HIGH = 2'd1,
    REG_WILDCARD     = 2'd2,
    REG_LENGTH       = 2'd3
  } cfg_reg_t;

  // Per-cycle control handed to every cell of the window.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

### design/wbps_if.sv
// Byte channel into the scanner.
interface wbps_byte_if;
  import wbps_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result channel out of the scanner.
interface wbps_result_if;
  import wbps_pkg::*;

  logic                valid;
  logic                ready;
  logic                found;
  logic [RESULT_W-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

### design/wbps_cell.sv
module wbps_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  wbps_pkg::cell_ctrl_t      ctrl,
  input  logic [wbps_pkg::BYTE_W-1:0] byte_in,
  input  logic [wbps_pkg::BYTE_W-1:0] expected,
  input  logic                      care,
  output logic [wbps_pkg::BYTE_W-1:0] byte_out,
  output logic                      hit
);
  import wbps_pkg::*;

  logic [BYTE_W-1:0] stored;

  // The byte entering this cell is compared against its pattern byte.
  assign hit      = !care || (byte_in == expected);
  assign byte_out = stored;

  // Hold one byte of the window; a range end empties the cell.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      stored <= '0;
    end else if (ctrl.shift) begin
      stored <= byte_in;
    end
  end
endmodule

### design/wildcard_byte_pattern_scan_core.sv
// A result is presented in the cycle after the beat that completes the match, or that ends a range with no match yet.
// Throughput: one byte per cycle; all window positions are compared in parallel in the cell row.
// The byte channel stalls only while a result beat waits to be taken.
// Reset (rst, synchronous, active high) restores the register defaults (pattern length 1),
// empties the window, clears the byte position and the done flag, and drops the result beat.
module wildcard_byte_pattern_scan_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data,
  wbps_byte_if.sink                       in_ch,
  wbps_result_if.source                   out_ch
);
  import wbps_pkg::*;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [MASK_W-1:0]     wildcard_mask;
  logic [LEN_W-1:0]      pattern_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      wildcard_mask  <= '0;
      pattern_length <= LEN_W'(1);
    end else if (cfg_write_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        REG_WILDCARD:     wildcard_mask  <= cfg_data[MASK_W-1:0];
        REG_LENGTH:       pattern_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective pattern length, kept between one and the cap.
  logic [LEN_W-1:0] eff_len;
  always_comb begin
    if (pattern_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (pattern_length > LEN_W'(LEN_CAP)) begin
      eff_len = LEN_W'(LEN_CAP);
    end else begin
      eff_len = pattern_length;
    end
  end

  logic [PAT_SLOTS*BYTE_W-1:0] pattern_vec;
  assign pattern_vec = {pattern_high, pattern_low};

  // Handshake and range state.
  logic                   accept;
  logic                   range_end;
  logic                   search_done;
  logic [OFFSET_BITS-1:0] byte_position;
  logic [OFFSET_BITS-1:0] byte_position_next;
  logic                   out_valid;
  logic                   out_found;
  logic [RESULT_W-1:0]    out_offset;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign range_end   = accept && in_ch.last_byte;

  cell_ctrl_t ctrl;
  assign ctrl.shift = accept;
  assign ctrl.clear = range_end;

  // Row of window cells; cell k is fed the byte received k beats before the incoming one.
  logic [MAX_PATTERN_BYTES-1:0] hits;
  logic [BYTE_W-1:0]            chain [MAX_PATTERN_BYTES-1];

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    logic [LEN_W-1:0]  slot;
    logic [BYTE_W-1:0] cell_in;
    logic              active;
    logic              care;

    // Cell k lines up with pattern byte (length - 1 - k); cells past the cap never take part.
    assign slot   = eff_len - LEN_W'(k + 1);
    assign active = (k < LEN_CAP) && (LEN_W'(k) < eff_len);
    assign care   = active && !wildcard_mask[slot[SLOT_W-1:0]];

    if (k == 0) begin : g_head
      assign cell_in = in_ch.data_byte;
    end else begin : g_body
      assign cell_in = chain[k-1];
    end

    if (k < MAX_PATTERN_BYTES - 1) begin : g_link
      wbps_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .byte_in  (cell_in),
        .expected (pattern_vec[slot[SLOT_W-1:0]*BYTE_W +: BYTE_W]),
        .care     (care),
        .byte_out (chain[k]),
        .hit      (hits[k])
      );
    end else begin : g_tail
      wbps_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .byte_in  (cell_in),
        .expected (pattern_vec[slot[SLOT_W-1:0]*BYTE_W +: BYTE_W]),
        .care     (care),
        .byte_out (),
        .hit      (hits[k])
      );
    end
  end

  // Saturating byte count including the incoming byte.
  assign byte_position_next = (byte_position != POS_MAX) ? byte_position + 1'b1
                                                         : byte_position;

  logic              window_full;
  logic              match;
  logic              give_result;
  logic [CALC_W-1:0] offset_calc;

  assign window_full = byte_position_next >= OFFSET_BITS'(eff_len);
  assign match       = !search_done && window_full && (&hits);
  assign give_result = accept && (match || (!search_done && in_ch.last_byte));
  assign offset_calc = CALC_W'(byte_position_next) - CALC_W'(eff_len);

  // Position and done flag; both restart at the end of a range.
  always_ff @(posedge clk) begin
    if (rst || range_end) begin
      byte_position <= '0;
      search_done   <= 1'b0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      if (match) begin
        search_done <= 1'b1;
      end
    end
  end

  // Result register: one beat held until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (give_result) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (give_result) begin
      out_found  <= match;
      out_offset <= match ? offset_calc[RESULT_W-1:0] : '0;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.found        = out_found;
  assign out_ch.match_offset = out_offset;
endmodule

### design/wbps_checker.sv
`include "wildcard_byte_pattern_scan_core_defines.svh"

module wbps_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_found,
  input logic [wbps_pkg::RESULT_W-1:0] out_offset
);
  import wbps_pkg::*;

  // A result beat only follows an accepted byte beat.
  `WBPS_ASSERT_IMP(a_result_needs_byte, $rose(out_valid), $past(in_valid && in_ready))

  // A range that ends without a match reports offset zero.
  `WBPS_ASSERT_IMP(a_miss_offset_zero, out_valid && !out_found, out_offset == '0)

  // The byte channel is open whenever no result beat is pending.
  `WBPS_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)

  // A result beat that is not taken stays presented.
  `WBPS_ASSERT_NXT(a_result_holds, out_valid && !out_ready, out_valid)

  // Reset drops any pending result.
  `WBPS_ASSERT_RST(a_reset_clears, rst, !out_valid)
endmodule

bind wildcard_byte_pattern_scan_core wbps_checker u_wbps_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_found  (out_ch.found),
  .out_offset (out_ch.match_offset)
);
